/* hdl/pt2d_pkg.sv */
package pt2d_pkg;

	// defaults for the top level parameters
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int POS_WIDTH_DEF    = 32;

	localparam int FULL_DEG    = 360;
	localparam int QUARTER_DEG = 90;

	// heading in degrees, unsigned q9.8
	localparam int HEAD_W = 17;
	localparam int TURN_W = 18;
	localparam logic [HEAD_W-1:0] FULL_TURN = HEAD_W'(FULL_DEG * 256);

	// cordic angle in degrees * 65536, vectors in q4.30
	localparam int ANG_W = 26;
	localparam int VEC_W = 34;
	localparam int TRIG_W = 16;
	localparam logic signed [ANG_W-1:0] ANG_QUARTER = ANG_W'(QUARTER_DEG * 65536);
	localparam logic signed [ANG_W-1:0] ANG_HALF    = ANG_W'(2 * QUARTER_DEG * 65536);
	localparam logic signed [ANG_W-1:0] ANG_3QUART  = ANG_W'(3 * QUARTER_DEG * 65536);
	localparam logic signed [ANG_W-1:0] ANG_FULL    = ANG_W'(FULL_DEG * 65536);
	localparam logic signed [VEC_W-1:0] CORDIC_GAIN = VEC_W'(652032874);
	localparam logic signed [TRIG_W-1:0] TRIG_ONE   = TRIG_W'(16384);

	typedef enum logic [1:0] {
		ACT_TRANSLATE = 2'd0,
		ACT_FORWARD   = 2'd1,
		ACT_ROTATE    = 2'd2,
		ACT_NONE      = 2'd3
	} act_t;

	typedef enum logic [2:0] {
		POS_HOLD,
		POS_TRANS,
		POS_MUL_SIN,
		POS_X_MUL_COS,
		POS_ADD_Y
	} pos_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TRANS,
		ST_MUL_SIN,
		ST_MUL_COS,
		ST_ADD_Y,
		ST_TURN,
		ST_SPIN,
		ST_CORDIC,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic [HEAD_W-1:0] heading;
	} cordic_req_t;

	// atan(2^-i) in degrees * 65536
	function automatic logic signed [ANG_W-1:0] atan_deg16(input logic [4:0] idx);
		logic signed [ANG_W-1:0] v;
		unique case (idx)
			5'd0:  v = ANG_W'(2949120);
			5'd1:  v = ANG_W'(1740967);
			5'd2:  v = ANG_W'(919879);
			5'd3:  v = ANG_W'(466945);
			5'd4:  v = ANG_W'(234379);
			5'd5:  v = ANG_W'(117304);
			5'd6:  v = ANG_W'(58666);
			5'd7:  v = ANG_W'(29335);
			5'd8:  v = ANG_W'(14668);
			5'd9:  v = ANG_W'(7334);
			5'd10: v = ANG_W'(3667);
			5'd11: v = ANG_W'(1833);
			5'd12: v = ANG_W'(917);
			5'd13: v = ANG_W'(458);
			5'd14: v = ANG_W'(229);
			5'd15: v = ANG_W'(115);
			5'd16: v = ANG_W'(57);
			5'd17: v = ANG_W'(29);
			5'd18: v = ANG_W'(14);
			5'd19: v = ANG_W'(7);
			5'd20: v = ANG_W'(4);
			5'd21: v = ANG_W'(2);
			5'd22: v = ANG_W'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

/* hdl/pt2d_cordic.sv */
module pt2d_cordic #(
	parameter int CORDIC_STEPS = pt2d_pkg::CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  pt2d_pkg::cordic_req_t req,
	output logic done,
	output logic signed [pt2d_pkg::TRIG_W-1:0] cos_val,
	output logic signed [pt2d_pkg::TRIG_W-1:0] sin_val
);

	localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);
	localparam int VW = pt2d_pkg::VEC_W;
	localparam int AW = pt2d_pkg::ANG_W;
	localparam int TW = pt2d_pkg::TRIG_W;

	logic busy_q, fin_q, neg_q;
	logic [STEP_W-1:0] step_q;
	logic signed [VW-1:0] x_q, y_q;
	logic signed [AW-1:0] a_q;
	logic signed [TW-1:0] cos_q, sin_q;

	logic signed [AW-1:0] a_raw, a_red;
	logic neg_red;
	logic signed [VW-1:0] xs, ys, xf, yf;
	logic signed [VW:0] xr_sum, yr_sum;
	logic signed [18:0] xr, yr;
	logic signed [AW-1:0] atan_v;

	// fold the heading into -90..90 degrees
	always_comb begin
		a_raw   = AW'({req.heading, 8'h00});
		a_red   = a_raw;
		neg_red = 1'b0;
		if (a_raw > pt2d_pkg::ANG_3QUART) begin
			a_red = a_raw - pt2d_pkg::ANG_FULL;
		end else if (a_raw > pt2d_pkg::ANG_QUARTER) begin
			a_red   = a_raw - pt2d_pkg::ANG_HALF;
			neg_red = 1'b1;
		end
	end

	assign xs     = x_q >>> step_q;
	assign ys     = y_q >>> step_q;
	assign atan_v = pt2d_pkg::atan_deg16(5'(step_q));

	// round half up to q2.14
	assign xf     = neg_q ? -x_q : x_q;
	assign yf     = neg_q ? -y_q : y_q;
	assign xr_sum = (VW+1)'(xf) + (VW+1)'(32768);
	assign yr_sum = (VW+1)'(yf) + (VW+1)'(32768);
	assign xr     = xr_sum[VW:16];
	assign yr     = yr_sum[VW:16];

	function automatic logic signed [TW-1:0] clamp14(input logic signed [18:0] v);
		logic signed [TW-1:0] r;
		if (v > 19'sd16384) begin
			r = pt2d_pkg::TRIG_ONE;
		end else if (v < -19'sd16384) begin
			r = -pt2d_pkg::TRIG_ONE;
		end else begin
			r = v[TW-1:0];
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			step_q <= '0;
			cos_q  <= pt2d_pkg::TRIG_ONE;
			sin_q  <= '0;
		end else begin
			fin_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_LAST) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
			if (fin_q) begin
				cos_q <= clamp14(xr);
				sin_q <= clamp14(yr);
			end
		end
	end

	// vector datapath, one micro-rotation per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q   <= pt2d_pkg::CORDIC_GAIN;
			y_q   <= '0;
			a_q   <= a_red;
			neg_q <= neg_red;
		end else if (busy_q) begin
			if (!a_q[AW-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				a_q <= a_q - atan_v;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				a_q <= a_q + atan_v;
			end
		end
	end

	assign done    = fin_q;
	assign cos_val = cos_q;
	assign sin_val = sin_q;

endmodule

/* hdl/pt2d_pos.sv */
module pt2d_pos #(
	parameter int POS_WIDTH = pt2d_pkg::POS_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  pt2d_pkg::pos_op_t op,
	input  logic signed [31:0] off_x,
	input  logic signed [31:0] off_y,
	input  logic signed [31:0] dist_val,
	input  logic signed [pt2d_pkg::TRIG_W-1:0] cos_val,
	input  logic signed [pt2d_pkg::TRIG_W-1:0] sin_val,
	output logic signed [POS_WIDTH-1:0] pos_x,
	output logic signed [POS_WIDTH-1:0] pos_y
);

	localparam int SW = ((POS_WIDTH > 33) ? POS_WIDTH : 33) + 1;
	localparam logic signed [SW-1:0] SAT_HI = {{(SW-POS_WIDTH+1){1'b0}}, {(POS_WIDTH-1){1'b1}}};
	localparam logic signed [SW-1:0] SAT_LO = {{(SW-POS_WIDTH+1){1'b1}}, {(POS_WIDTH-1){1'b0}}};
	localparam int PW = 32 + pt2d_pkg::TRIG_W;

	logic signed [POS_WIDTH-1:0] pos_x_q, pos_y_q;
	logic signed [PW-1:0] prod_q;
	logic signed [pt2d_pkg::TRIG_W-1:0] trig;
	logic signed [PW:0] prod_rnd;
	logic signed [32:0] delta;
	logic signed [SW-1:0] sum_tx, sum_ty, add_a, add_b, sum_f;

	function automatic logic signed [POS_WIDTH-1:0] sat(input logic signed [SW-1:0] v);
		logic signed [POS_WIDTH-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[POS_WIDTH-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[POS_WIDTH-1:0];
		end else begin
			r = v[POS_WIDTH-1:0];
		end
		return r;
	endfunction

	assign trig     = (op == pt2d_pkg::POS_MUL_SIN) ? sin_val : cos_val;
	// round half up back to q16.16
	assign prod_rnd = (PW+1)'(prod_q) + (PW+1)'(8192);
	assign delta    = prod_rnd[46:14];

	assign sum_tx = SW'(pos_x_q) + SW'(off_x);
	assign sum_ty = SW'(pos_y_q) + SW'(off_y);
	assign add_a  = (op == pt2d_pkg::POS_X_MUL_COS) ? SW'(pos_x_q) : SW'(pos_y_q);
	assign add_b  = (op == pt2d_pkg::POS_X_MUL_COS) ? -SW'(delta) : SW'(delta);
	assign sum_f  = add_a + add_b;

	always_ff @(posedge clk) begin
		if (op == pt2d_pkg::POS_MUL_SIN || op == pt2d_pkg::POS_X_MUL_COS) begin
			prod_q <= dist_val * trig;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
		end else begin
			unique case (op)
				pt2d_pkg::POS_TRANS: begin
					pos_x_q <= sat(sum_tx);
					pos_y_q <= sat(sum_ty);
				end
				pt2d_pkg::POS_X_MUL_COS: pos_x_q <= sat(sum_f);
				pt2d_pkg::POS_ADD_Y:     pos_y_q <= sat(sum_f);
				default: ;
			endcase
		end
	end

	assign pos_x = pos_x_q;
	assign pos_y = pos_y_q;

endmodule

/* hdl/pose_tracker_2d.sv */
// pose_tracker_2d keeps a 2d viewer pose (x, y in q16.16, heading in q9.8
// degrees) and reports, for every input word, the pose after it together with
// cos and sin of the heading in q2.14. action 0 translates by offset_x/offset_y,
// action 1 moves by distance along the heading (heading 0 faces north, so x
// drops by d*sin and y grows by d*cos), action 2 turns by turn_angle and wraps
// the heading once into 0..360, action 3 leaves the pose as it is. position
// saturates to POS_WIDTH signed bits; x_pos/y_pos show its low 32 bits. one
// word is worked on at a time and in_ready stays low meanwhile: a translate
// runs ST_TRANS, a forward move ST_MUL_SIN, ST_MUL_COS and ST_ADD_Y (one shared
// 32x16 multiplier used for sin then cos, one saturating adder), a turn ST_TURN,
// ST_SPIN and ST_CORDIC, the iterative cordic doing one micro-rotation per
// cycle, and all end in ST_DONE, which action 3 enters at once and which waits
// while an unread result fills the output register. in_ready comes back with
// out_valid. the result sits in an output register, so a new word is taken
// while the previous result still waits for out_ready.
module pose_tracker_2d #(
	parameter int CORDIC_STEPS = pt2d_pkg::CORDIC_STEPS_DEF,
	parameter int POS_WIDTH    = pt2d_pkg::POS_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] action,
	input  logic signed [31:0] offset_x,
	input  logic signed [31:0] offset_y,
	input  logic signed [31:0] distance,
	input  logic signed [pt2d_pkg::TURN_W-1:0] turn_angle,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [31:0] x_pos,
	output logic signed [31:0] y_pos,
	output logic [pt2d_pkg::HEAD_W-1:0] heading_out,
	output logic signed [pt2d_pkg::TRIG_W-1:0] cos_out,
	output logic signed [pt2d_pkg::TRIG_W-1:0] sin_out
);

	localparam int EXT_W = (POS_WIDTH > 32) ? POS_WIDTH : 32;
	localparam int HW = pt2d_pkg::HEAD_W;
	localparam int TW = pt2d_pkg::TURN_W;

	pt2d_pkg::state_t state_q, state_nxt;
	pt2d_pkg::pos_op_t pos_op;
	pt2d_pkg::cordic_req_t cordic_req;

	logic accept, out_free, cordic_done;

	// captured input word
	logic signed [31:0] off_x_q, off_y_q, dist_q;
	logic signed [TW-1:0] turn_q;

	logic [HW-1:0] heading_q;
	logic signed [TW-1:0] turn_clamped;
	logic signed [TW:0] head_sum;
	logic [HW-1:0] head_new;

	logic signed [POS_WIDTH-1:0] pos_x, pos_y;
	logic signed [EXT_W-1:0] x_ext, y_ext;
	logic signed [pt2d_pkg::TRIG_W-1:0] cos_val, sin_val;

	logic out_valid_q;
	logic signed [31:0] x_pos_q, y_pos_q;
	logic [HW-1:0] heading_out_q;
	logic signed [pt2d_pkg::TRIG_W-1:0] cos_out_q, sin_out_q;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// sequencer
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			pt2d_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (pt2d_pkg::act_t'(action))
						pt2d_pkg::ACT_TRANSLATE: state_nxt = pt2d_pkg::ST_TRANS;
						pt2d_pkg::ACT_FORWARD:   state_nxt = pt2d_pkg::ST_MUL_SIN;
						pt2d_pkg::ACT_ROTATE:    state_nxt = pt2d_pkg::ST_TURN;
						pt2d_pkg::ACT_NONE:      state_nxt = pt2d_pkg::ST_DONE;
					endcase
				end
			end
			pt2d_pkg::ST_TRANS:   state_nxt = pt2d_pkg::ST_DONE;
			pt2d_pkg::ST_MUL_SIN: state_nxt = pt2d_pkg::ST_MUL_COS;
			pt2d_pkg::ST_MUL_COS: state_nxt = pt2d_pkg::ST_ADD_Y;
			pt2d_pkg::ST_ADD_Y:   state_nxt = pt2d_pkg::ST_DONE;
			pt2d_pkg::ST_TURN:    state_nxt = pt2d_pkg::ST_SPIN;
			pt2d_pkg::ST_SPIN:    state_nxt = pt2d_pkg::ST_CORDIC;
			pt2d_pkg::ST_CORDIC: begin
				if (cordic_done) begin
					state_nxt = pt2d_pkg::ST_DONE;
				end
			end
			pt2d_pkg::ST_DONE: begin
				if (out_free) begin
					state_nxt = pt2d_pkg::ST_IDLE;
				end
			end
			default: state_nxt = pt2d_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		pos_op             = pt2d_pkg::POS_HOLD;
		cordic_req.start   = 1'b0;
		cordic_req.heading = heading_q;
		in_ready           = 1'b0;
		unique case (state_q)
			pt2d_pkg::ST_IDLE:    in_ready = 1'b1;
			pt2d_pkg::ST_TRANS:   pos_op = pt2d_pkg::POS_TRANS;
			pt2d_pkg::ST_MUL_SIN: pos_op = pt2d_pkg::POS_MUL_SIN;
			pt2d_pkg::ST_MUL_COS: pos_op = pt2d_pkg::POS_X_MUL_COS;
			pt2d_pkg::ST_ADD_Y:   pos_op = pt2d_pkg::POS_ADD_Y;
			pt2d_pkg::ST_SPIN:    cordic_req.start = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pt2d_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			off_x_q <= offset_x;
			off_y_q <= offset_y;
			dist_q  <= distance;
			turn_q  <= turn_angle;
		end
	end

	// heading update: clamp the turn to one revolution, wrap once
	always_comb begin
		if (turn_q > TW'(signed'({1'b0, pt2d_pkg::FULL_TURN}))) begin
			turn_clamped = TW'(signed'({1'b0, pt2d_pkg::FULL_TURN}));
		end else if (turn_q < -TW'(signed'({1'b0, pt2d_pkg::FULL_TURN}))) begin
			turn_clamped = -TW'(signed'({1'b0, pt2d_pkg::FULL_TURN}));
		end else begin
			turn_clamped = turn_q;
		end
		head_sum = (TW+1)'(signed'({1'b0, heading_q})) + (TW+1)'(turn_clamped);
		if (head_sum > (TW+1)'(signed'({1'b0, pt2d_pkg::FULL_TURN}))) begin
			head_new = HW'(head_sum - (TW+1)'(signed'({1'b0, pt2d_pkg::FULL_TURN})));
		end else if (head_sum < 0) begin
			head_new = HW'(head_sum + (TW+1)'(signed'({1'b0, pt2d_pkg::FULL_TURN})));
		end else begin
			head_new = HW'(head_sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_q <= '0;
		end else if (state_q == pt2d_pkg::ST_TURN) begin
			heading_q <= head_new;
		end
	end

	pt2d_pos #(
		.POS_WIDTH(POS_WIDTH)
	) u_pos (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (pos_op),
		.off_x   (off_x_q),
		.off_y   (off_y_q),
		.dist_val(dist_q),
		.cos_val (cos_val),
		.sin_val (sin_val),
		.pos_x   (pos_x),
		.pos_y   (pos_y)
	);

	pt2d_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cordic_req),
		.done   (cordic_done),
		.cos_val(cos_val),
		.sin_val(sin_val)
	);

	// position shown as its low 32 bits, sign extended when narrower
	assign x_ext = EXT_W'(pos_x);
	assign y_ext = EXT_W'(pos_y);

	// output register holds the result word until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == pt2d_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pt2d_pkg::ST_DONE && out_free) begin
			x_pos_q       <= x_ext[31:0];
			y_pos_q       <= y_ext[31:0];
			heading_out_q <= heading_q;
			cos_out_q     <= cos_val;
			sin_out_q     <= sin_val;
		end
	end

	assign out_valid   = out_valid_q;
	assign x_pos       = x_pos_q;
	assign y_pos       = y_pos_q;
	assign heading_out = heading_out_q;
	assign cos_out     = cos_out_q;
	assign sin_out     = sin_out_q;

endmodule
